/* rtl/rcnls_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest level search package
// Shared widths, constants, opcodes, status codes and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package rcnls_pkg;

  localparam int unsigned MaxLevelsDef = 256;
  localparam int unsigned EnergyW      = 25;
  localparam int unsigned TargetW      = 26;
  localparam int unsigned RecipW       = 32;
  localparam int unsigned SquareW      = 2 * EnergyW;
  localparam int unsigned ProdW        = EnergyW + RecipW;
  localparam int unsigned AccW         = SquareW + RecipW;
  localparam int unsigned RecoilShift  = 56;
  localparam int unsigned LevelIdxW    = 8;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [TargetW-1:0] TargetMax = {1'b0, {(TargetW-1){1'b1}}};
  localparam logic [TargetW-1:0] TargetMin = {1'b1, {(TargetW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_ABSORB = 2'd2,
    OP_EMIT   = 2'd3
  } rcnls_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } rcnls_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_DIFF = 1'b0,
    CFG_RECIP    = 1'b1
  } rcnls_cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RECOIL,
    S_TARGET,
    S_WALK
  } rcnls_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI
  } rcnls_mul_e;

endpackage

`default_nettype wire

/* rtl/rcnls_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rcnls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/rcnls_recoil.sv */
// ----------------------------------------------------------------------------
// Recoil product unit
// Forms floor(g * g * r / 2^56) with one shared 25x32 multiplier used in
// three steps: the square, then the low and high halves times r.
// ----------------------------------------------------------------------------
`default_nettype none

module rcnls_recoil
  import rcnls_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [EnergyW-1:0] gamma_i,
  input  wire logic [RecipW-1:0]  recip_i,
  output logic                    done_o,
  output logic [TargetW-1:0]      recoil_o
);

  rcnls_mul_e phase_q, phase_d;

  logic [EnergyW-1:0] mul_a;
  logic [RecipW-1:0]  mul_b;
  logic [ProdW-1:0]   prod;
  logic [SquareW-1:0] sq_q;
  logic [AccW-1:0]    acc_q;
  logic               done_q;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      MUL_IDLE: begin
        if (start_i) begin
          phase_d = MUL_LO;
        end
      end
      MUL_LO:  phase_d = MUL_HI;
      MUL_HI:  phase_d = MUL_IDLE;
      default: phase_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    case (phase_q)
      MUL_LO: begin
        mul_a = sq_q[EnergyW-1:0];
        mul_b = recip_i;
      end
      MUL_HI: begin
        mul_a = sq_q[SquareW-1:EnergyW];
        mul_b = recip_i;
      end
      default: begin
        mul_a = gamma_i;
        mul_b = {{(RecipW-EnergyW){1'b0}}, gamma_i};
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == MUL_HI);
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      MUL_IDLE: begin
        if (start_i) begin
          sq_q <= prod[SquareW-1:0];
        end
      end
      MUL_LO:  acc_q <= {{(AccW-ProdW){1'b0}}, prod};
      MUL_HI:  acc_q <= acc_q + {prod, {EnergyW{1'b0}}};
      default: acc_q <= acc_q;
    endcase
  end

  assign done_o   = done_q;
  assign recoil_o = acc_q[AccW-1:RecoilShift];

endmodule

`default_nettype wire

/* rtl/recoil_corrected_nearest_level_search.sv */
// ----------------------------------------------------------------------------
// Recoil-corrected nearest level search
// Append and clear words give their result strobe in the cycle after acceptance
// and the block is ready again in that cycle.
// A query runs the recoil product, then forms the saturated target, then walks
// k table entries (at most the table size) in order from entry 0;
// the walk reads one entry per cycle from the single table read port.
// Reset is asynchronous: count and configuration clear, table contents do not.
// ----------------------------------------------------------------------------
`default_nettype none

module recoil_corrected_nearest_level_search
  import rcnls_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MaxLevelsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation_i,
  input  wire logic [EnergyW-1:0]  energy_i,
  input  wire logic [EnergyW-1:0]  start_level_energy_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [LevelIdxW-1:0]     level_index_o,
  output logic [EnergyW-1:0]       level_energy_o,
  output logic [TargetW-1:0]       target_energy_o
);

  localparam int unsigned IdxW = $clog2(MAX_LEVELS);
  localparam int unsigned CntW = $clog2(MAX_LEVELS + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MAX_LEVELS);

  rcnls_state_e state_q, state_d;

  logic [EnergyW-1:0] max_diff_q;
  logic [RecipW-1:0]  recip_q;
  logic [CntW-1:0]    count_q;

  logic [1:0]         op_q;
  logic [EnergyW-1:0] gamma_q;
  logic [EnergyW-1:0] start_lvl_q;
  logic [TargetW-1:0] target_q;

  logic [CntW-1:0]    idx_q;
  logic [EnergyW-1:0] last_q;
  logic [TargetW-1:0] prev_d_q;
  logic [TargetW-1:0] best_d_q;
  logic [IdxW-1:0]    best_i_q;
  logic [EnergyW-1:0] best_e_q;
  logic               found_q;

  logic               done_q;
  logic [1:0]         status_q;
  logic [LevelIdxW-1:0] lidx_q;
  logic [EnergyW-1:0] lenergy_q;
  logic [TargetW-1:0] tenergy_q;

  logic accept;
  logic is_query;
  logic full;
  logic ram_we;
  logic mul_start;
  logic [IdxW-1:0]    ram_raddr;
  logic [EnergyW-1:0] ram_rdata;
  logic               mul_done;
  logic [TargetW-1:0] recoil;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign is_query = (operation_i == OP_ABSORB) || (operation_i == OP_EMIT);
  assign full     = (count_q == FullCnt);

  // Recoil-corrected target with saturation.
  logic [TargetW+1:0] base;
  logic [TargetW+1:0] t_full;
  logic [TargetW-1:0] t_sat;

  always_comb begin
    if (op_q == OP_ABSORB) begin
      base = {3'b000, gamma_q};
    end else begin
      base = {3'b000, start_lvl_q} - {3'b000, gamma_q};
    end
    t_full = base - {2'b00, recoil};
    if (t_full[TargetW+1:TargetW-1] == 3'b000 || t_full[TargetW+1:TargetW-1] == 3'b111) begin
      t_sat = t_full[TargetW-1:0];
    end else if (t_full[TargetW+1]) begin
      t_sat = TargetMin;
    end else begin
      t_sat = TargetMax;
    end
  end

  // One walk step on the entry read in the previous cycle.
  logic [EnergyW-1:0] lv;
  logic [TargetW:0]   dif;
  logic [TargetW:0]   dif_neg;
  logic [TargetW-1:0] lvl_dist;
  logic               bad;
  logic               upd;
  logic               rising;
  logic [CntW-1:0]    idx_nxt;
  logic               stop;
  logic               found_n;
  logic [IdxW-1:0]    best_i_n;
  logic [EnergyW-1:0] best_e_n;
  logic [IdxW+LevelIdxW-1:0] best_i_ext;
  logic [IdxW+LevelIdxW-1:0] count_ext;

  always_comb begin
    lv       = ram_rdata;
    bad      = (lv <= last_q);
    dif      = {2'b00, lv} - {target_q[TargetW-1], target_q};
    dif_neg  = -dif;
    lvl_dist = dif[TargetW] ? dif_neg[TargetW-1:0] : dif[TargetW-1:0];
    upd      = (lvl_dist <= {1'b0, max_diff_q}) && (!found_q || lvl_dist < best_d_q);
    rising   = (idx_q != '0) && (lvl_dist > prev_d_q);
    idx_nxt  = idx_q + CntW'(1);
    stop     = bad || rising || (idx_nxt == count_q);
    found_n  = found_q || upd;
    best_i_n = upd ? idx_q[IdxW-1:0] : best_i_q;
    best_e_n = upd ? lv : best_e_q;
    best_i_ext = {{LevelIdxW{1'b0}}, best_i_n};
    count_ext  = {{LevelIdxW{1'b0}}, count_q[IdxW-1:0]};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && is_query) begin
          state_d = S_RECOIL;
        end
      end
      S_RECOIL: begin
        if (mul_done) begin
          state_d = S_TARGET;
        end
      end
      S_TARGET: state_d = (count_q == '0) ? S_IDLE : S_WALK;
      S_WALK: begin
        if (stop) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ram_we    = 1'b0;
    mul_start = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        ram_we    = accept && (operation_i == OP_APPEND) && !full;
        mul_start = accept && is_query;
      end
      S_WALK:  ram_raddr = idx_nxt[IdxW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      max_diff_q <= '0;
      recip_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_DIFF: max_diff_q <= cfg_wdata_i[EnergyW-1:0];
          CFG_RECIP:    recip_q    <= cfg_wdata_i[RecipW-1:0];
          default:      max_diff_q <= max_diff_q;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (operation_i == OP_APPEND) begin
              done_q <= 1'b1;
              if (!full) begin
                count_q <= count_q + CntW'(1);
              end
            end else if (operation_i == OP_CLEAR) begin
              done_q  <= 1'b1;
              count_q <= '0;
            end
          end
        end
        S_TARGET: begin
          if (count_q == '0) begin
            done_q <= 1'b1;
          end
        end
        S_WALK: begin
          if (stop) begin
            done_q <= 1'b1;
          end
        end
        default: done_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q        <= operation_i;
          gamma_q     <= energy_i;
          start_lvl_q <= start_level_energy_i;
          tenergy_q   <= '0;
          if (operation_i == OP_APPEND && !full) begin
            status_q  <= ST_OK;
            lidx_q    <= count_ext[LevelIdxW-1:0];
            lenergy_q <= energy_i;
          end else begin
            status_q  <= (operation_i == OP_APPEND) ? ST_FULL : ST_OK;
            lidx_q    <= '0;
            lenergy_q <= '0;
          end
        end
      end
      S_TARGET: begin
        target_q <= t_sat;
        idx_q    <= '0;
        last_q   <= '0;
        found_q  <= 1'b0;
        if (count_q == '0) begin
          status_q  <= ST_NONE;
          lidx_q    <= '0;
          lenergy_q <= '0;
          tenergy_q <= t_sat;
        end
      end
      S_WALK: begin
        idx_q    <= idx_nxt;
        last_q   <= lv;
        prev_d_q <= lvl_dist;
        found_q  <= found_n;
        best_i_q <= best_i_n;
        best_e_q <= best_e_n;
        if (upd) begin
          best_d_q <= lvl_dist;
        end
        if (stop) begin
          tenergy_q <= target_q;
          if (bad) begin
            status_q  <= ST_ORDER;
            lidx_q    <= '0;
            lenergy_q <= '0;
          end else if (!found_n) begin
            status_q  <= ST_NONE;
            lidx_q    <= '0;
            lenergy_q <= '0;
          end else begin
            status_q  <= ST_OK;
            lidx_q    <= best_i_ext[LevelIdxW-1:0];
            lenergy_q <= best_e_n;
          end
        end
      end
      default: target_q <= target_q;
    endcase
  end

  rcnls_ram #(
    .Width (EnergyW),
    .Depth (MAX_LEVELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (energy_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rcnls_recoil u_recoil (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .gamma_i  (energy_i),
    .recip_i  (recip_q),
    .done_o   (mul_done),
    .recoil_o (recoil)
  );

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign level_index_o   = lidx_q;
  assign level_energy_o  = lenergy_q;
  assign target_energy_o = tenergy_q;

endmodule

`default_nettype wire

/* rtl/rcnls_checker.sv */
// ----------------------------------------------------------------------------
// Nearest level search port checker
// Watches the top-level ports for timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module rcnls_checker
  import rcnls_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [1:0]          operation_i,
  input wire logic                done_o,
  input wire logic [1:0]          status_o,
  input wire logic [LevelIdxW-1:0] level_index_o,
  input wire logic [EnergyW-1:0]  level_energy_o,
  input wire logic [TargetW-1:0]  target_energy_o
);

  logic acc;
  assign acc = start && !busy;

  // A result word only follows an accepted word or work in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(acc) || $past(busy)))
    else $error("result word without a pending word");

  // Table updates give their result word in the cycle after acceptance and leave the block ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (operation_i == OP_APPEND || operation_i == OP_CLEAR)) |=> (done_o && !busy))
    else $error("append or clear did not complete in one cycle");

  // A query keeps the block busy and gives no immediate result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (operation_i == OP_ABSORB || operation_i == OP_EMIT)) |=> (busy && !done_o))
    else $error("query did not start its search");

  // Failed searches and a full table report no level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (level_index_o == '0 && level_energy_o == '0))
    else $error("level reported with a failure status");

  // Clear and append report a zero target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (operation_i == OP_APPEND || operation_i == OP_CLEAR)) |=> (target_energy_o == '0))
    else $error("nonzero target on a table update");

endmodule

bind recoil_corrected_nearest_level_search rcnls_checker u_rcnls_checker (.*);

`default_nettype wire

/* dv/level_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest level search checker
// Watches the command, configuration and result channels of the search block.
// Keeps its own copy of the level table and registers, predicts the result of
// every accepted word and compares each strobed result, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module level_search_checker
  import rcnls_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MaxLevelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [1:0]          operation_i,
  input  logic [EnergyW-1:0]  energy_i,
  input  logic [EnergyW-1:0]  start_level_energy_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                done_i,
  input  logic [1:0]          status_i,
  input  logic [LevelIdxW-1:0] level_index_i,
  input  logic [EnergyW-1:0]  level_energy_i,
  input  logic [TargetW-1:0]  target_energy_i,
  output int                  mismatch_count_o,
  output int                  pending_words_o
);

  localparam longint TargetHigh = (longint'(1) <<< (TargetW - 1)) - 1;
  localparam longint TargetLow  = -(longint'(1) <<< (TargetW - 1));

  typedef struct packed {
    rcnls_status_e          status;
    logic [LevelIdxW-1:0]   level_index;
    logic [EnergyW-1:0]     level_energy;
    logic [TargetW-1:0]     target_energy;
  } search_result_t;

  logic [EnergyW-1:0] level_table [MAX_LEVELS];
  int unsigned        level_count;
  logic [EnergyW-1:0] max_difference;
  logic [RecipW-1:0]  recoil_recip;
  search_result_t     results_due [$];
  int                 mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic search_result_t predict_search(input rcnls_op_e op,
                                                    input logic [EnergyW-1:0] gamma,
                                                    input logic [EnergyW-1:0] start_lvl);
    search_result_t     res;
    logic [SquareW-1:0] square;
    logic [AccW-1:0]    product;
    longint             recoil, target, lvl, lvl_dist, prev_dist, best_dist, last_lvl;
    int unsigned        best_idx;
    bit                 found, disorder;
    res = '0;
    case (op)
      OP_APPEND: begin
        if (level_count >= MAX_LEVELS) begin
          res.status = ST_FULL;
        end else begin
          level_table[level_count] = gamma;
          res.level_index  = LevelIdxW'(level_count);
          res.level_energy = gamma;
          level_count++;
        end
      end
      OP_CLEAR: begin
        level_count = 0;
      end
      default: begin
        square  = SquareW'(gamma) * SquareW'(gamma);
        product = AccW'(square) * AccW'(recoil_recip);
        recoil  = longint'(product >> RecoilShift);
        if (op == OP_ABSORB) begin
          target = longint'(gamma) - recoil;
        end else begin
          target = longint'(start_lvl) - longint'(gamma) - recoil;
        end
        if (target > TargetHigh) target = TargetHigh;
        if (target < TargetLow) target = TargetLow;

        // The walk stops on the first rise in distance; order is only checked
        // on the entries it actually reaches.
        last_lvl  = 0;
        prev_dist = 0;
        best_dist = 0;
        best_idx  = 0;
        found     = 1'b0;
        disorder  = 1'b0;
        for (int unsigned i = 0; i < level_count; i++) begin
          lvl = longint'(level_table[i]);
          if (lvl <= last_lvl) begin
            disorder = 1'b1;
            break;
          end
          last_lvl = lvl;
          lvl_dist = (lvl >= target) ? lvl - target : target - lvl;
          if (lvl_dist <= longint'(max_difference) && (!found || lvl_dist < best_dist)) begin
            found     = 1'b1;
            best_dist = lvl_dist;
            best_idx  = i;
          end
          if (i != 0 && lvl_dist > prev_dist) break;
          prev_dist = lvl_dist;
        end

        res.target_energy = target[TargetW-1:0];
        if (disorder) begin
          res.status = ST_ORDER;
        end else if (!found) begin
          res.status = ST_NONE;
        end else begin
          res.status       = ST_OK;
          res.level_index  = LevelIdxW'(best_idx);
          res.level_energy = level_table[best_idx];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    search_result_t oldest;
    if (!rst_ni) begin
      level_count    = 0;
      max_difference = '0;
      recoil_recip   = '0;
      results_due.delete();
      pending_words_o <= 0;
    end else begin
      if (done_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with nothing pending, status", '0, status_i);
        end else begin
          oldest = results_due.pop_front();
          if (status_i !== oldest.status)
            report_mismatch("status", oldest.status, status_i);
          if (level_index_i !== oldest.level_index)
            report_mismatch("level_index", oldest.level_index, level_index_i);
          if (level_energy_i !== oldest.level_energy)
            report_mismatch("level_energy", oldest.level_energy, level_energy_i);
          if (target_energy_i !== oldest.target_energy)
            report_mismatch("target_energy", oldest.target_energy, target_energy_i);
        end
      end
      if (start_i && !busy_i) begin
        results_due.insert(results_due.size(),
                           predict_search(rcnls_op_e'(operation_i), energy_i,
                                          start_level_energy_i));
      end
      if (cfg_we_i) begin
        case (rcnls_cfg_e'(cfg_idx_i))
          CFG_MAX_DIFF: max_difference = cfg_wdata_i[EnergyW-1:0];
          CFG_RECIP:    recoil_recip   = cfg_wdata_i[RecipW-1:0];
          default: ;
        endcase
      end
      pending_words_o <= results_due.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest level search testbench
// Loads level tables under several register settings, mostly ascending with
// occasional ordering faults, and issues absorb and emit queries aimed near
// stored levels, mixed with random words. Commands come in random bursts; a
// separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import rcnls_pkg::*;

  localparam int unsigned        MaxLevels       = MaxLevelsDef;
  localparam logic [EnergyW-1:0] EnergyMax       = '1;
  localparam int unsigned        RecipPerNucleon = 38678000;
  localparam int                 StallLimit      = 8 * (MaxLevels + 24);

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           operation_i = '0;
  logic [EnergyW-1:0]   energy_i = '0;
  logic [EnergyW-1:0]   start_level_energy_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [LevelIdxW-1:0] level_index_o;
  logic [EnergyW-1:0]   level_energy_o;
  logic [TargetW-1:0]   target_energy_o;

  int                   mismatch_count;
  int                   pending_words;
  int                   quiet_cycles = 0;
  int                   burst_left = 0;
  longint               max_diff_now = 0;
  logic [EnergyW-1:0]   staged_levels [$];

  recoil_corrected_nearest_level_search u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .operation_i          (operation_i),
    .energy_i             (energy_i),
    .start_level_energy_i (start_level_energy_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .done_o               (done_o),
    .status_o             (status_o),
    .level_index_o        (level_index_o),
    .level_energy_o       (level_energy_o),
    .target_energy_o      (target_energy_o)
  );

  level_search_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start),
    .busy_i               (busy),
    .operation_i          (operation_i),
    .energy_i             (energy_i),
    .start_level_energy_i (start_level_energy_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .done_i               (done_o),
    .status_i             (status_o),
    .level_index_i        (level_index_o),
    .level_energy_i       (level_energy_o),
    .target_energy_i      (target_energy_o),
    .mismatch_count_o     (mismatch_count),
    .pending_words_o      (pending_words)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [EnergyW-1:0] clip_energy(input longint value);
    if (value < 0) return '0;
    if (value > longint'(EnergyMax)) return EnergyMax;
    return value[EnergyW-1:0];
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic issue(input rcnls_op_e op, input logic [EnergyW-1:0] gamma,
                       input logic [EnergyW-1:0] start_lvl);
    pace();
    start                <= 1'b1;
    operation_i          <= op;
    energy_i             <= gamma;
    start_level_energy_i <= start_lvl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OP_APPEND && staged_levels.size() < MaxLevels) begin
      staged_levels.insert(staged_levels.size(), gamma);
    end
    if (op == OP_CLEAR) staged_levels.delete();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input rcnls_cfg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_MAX_DIFF) max_diff_now = longint'(data[EnergyW-1:0]);
  endtask

  task automatic aimed_query();
    longint lvl, gamma, spread, delta;
    if (staged_levels.size() == 0) begin
      issue($urandom_range(0, 1) ? OP_EMIT : OP_ABSORB, EnergyW'($urandom()),
            EnergyW'($urandom()));
      return;
    end
    lvl = longint'(staged_levels[$urandom_range(0, staged_levels.size() - 1)]);
    if (max_diff_now < 32) spread = 32;
    else if (max_diff_now > (1 << 20)) spread = 1 << 20;
    else spread = 2 * max_diff_now;
    delta = longint'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(0, 1)) begin
      issue(OP_ABSORB, clip_energy(lvl + delta), EnergyW'($urandom()));
    end else begin
      gamma = longint'($urandom_range(0, longint'(EnergyMax) - lvl) >> $urandom_range(0, 16));
      issue(OP_EMIT, clip_energy(gamma), clip_energy(lvl + gamma + delta));
    end
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] diff, input logic [CfgDataW-1:0] recip,
                           input int n_levels, input int n_queries, input int flaw_pct);
    longint next_lvl, last_lvl, step_max;
    int     roll;
    drain();
    write_reg(CFG_MAX_DIFF, diff);
    write_reg(CFG_RECIP, recip);
    issue(OP_CLEAR, EnergyW'($urandom()), EnergyW'($urandom()));
    next_lvl = longint'($urandom_range(1, 1000));
    last_lvl = 0;
    step_max = (longint'(EnergyMax) - next_lvl) / (n_levels + 1);
    step_max = step_max >> $urandom_range(0, 12);
    if (step_max < 1) step_max = 1;
    for (int k = 0; k < n_levels; k++) begin
      if ($urandom_range(0, 99) < flaw_pct) begin
        issue(OP_APPEND, (k == 0) ? '0 : clip_energy(longint'($urandom_range(0, last_lvl))),
              EnergyW'($urandom()));
      end else begin
        issue(OP_APPEND, clip_energy(next_lvl), EnergyW'($urandom()));
        last_lvl = next_lvl;
        next_lvl = next_lvl + longint'($urandom_range(1, step_max));
      end
    end
    for (int k = 0; k < n_queries; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) aimed_query();
      else if (roll < 92) issue(roll[0] ? OP_EMIT : OP_ABSORB, EnergyW'($urandom()),
                                EnergyW'($urandom()));
      else if (roll < 97) issue(OP_APPEND, EnergyW'($urandom()), EnergyW'($urandom()));
      else issue(OP_CLEAR, EnergyW'($urandom()), EnergyW'($urandom()));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_MAX_DIFF, CfgDataW'(EnergyMax));
    write_reg(CFG_RECIP, '0);
    issue(OP_ABSORB, EnergyMax, EnergyMax);
    issue(OP_EMIT, EnergyMax, '0);
    issue(OP_APPEND, '0, '0);
    issue(OP_ABSORB, EnergyW'(5), '0);
    issue(OP_CLEAR, '0, '0);
    issue(OP_APPEND, EnergyW'(100), '0);
    issue(OP_APPEND, EnergyW'(100), '0);
    issue(OP_ABSORB, EnergyW'(100), '0);
    issue(OP_CLEAR, '0, '0);
    issue(OP_APPEND, EnergyW'(1000), '0);
    issue(OP_APPEND, EnergyW'(2000), '0);
    issue(OP_APPEND, EnergyMax, '0);
    issue(OP_ABSORB, EnergyW'(1900), '0);
    issue(OP_ABSORB, EnergyMax, '0);
    issue(OP_EMIT, '0, EnergyMax);
    issue(OP_EMIT, '0, '0);
    drain();
    write_reg(CFG_RECIP, '1);
    write_reg(CFG_MAX_DIFF, '0);
    issue(OP_ABSORB, EnergyMax, '0);
    issue(OP_EMIT, EnergyMax, '0);
    issue(OP_ABSORB, EnergyW'(1000), '0);
    issue(OP_ABSORB, EnergyW'(1001), '0);

    run_phase(CfgDataW'(EnergyMax), '0, 20, 80, 0);
    run_phase('0, RecipPerNucleon / $urandom_range(1, 250), 30, 120, 2);
    run_phase('0, '0, 40, 120, 2);
    run_phase($urandom_range(1, 5000), RecipPerNucleon / $urandom_range(20, 250),
              MaxLevels + 5, 95, 0);
    run_phase('1, '1, 10, 100, 5);
    run_phase($urandom_range(0, 1 << 20), $urandom(), 60, 80, 3);
    run_phase($urandom_range(0, 50000), RecipPerNucleon / $urandom_range(1, 250), 5, 110, 5);
    run_phase($urandom(), '0, 1, 80, 10);
    run_phase($urandom_range(0, 2000), RecipPerNucleon / $urandom_range(1, 250), 50, 60, 1);

    drain();
    repeat (MaxLevels + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
